FILE: hdl/imhq_pkg.sv
`default_nettype none
package imhq_pkg;

  // Fixed field widths of the ports
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned KEYIN_W = 32;
  localparam int unsigned STAT_W  = 3;

  // Operation codes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_EXTRACT  = 2'd1;
  localparam logic [1:0] OP_CHANGE   = 2'd2;
  localparam logic [1:0] OP_CONTAINS = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT = 3'd4;

  // Heap read address selects
  localparam logic [2:0] HA_ROOT   = 3'd0;
  localparam logic [2:0] HA_LAST   = 3'd1;
  localparam logic [2:0] HA_PARENT = 3'd2;
  localparam logic [2:0] HA_LEFT   = 3'd3;
  localparam logic [2:0] HA_RIGHT  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic [2:0]        hsel;
    logic              cur_in;
    logic              cur_rd;
    logic              res_rd;
    logic              idx_cnt;
    logic              idx_slot;
    logic              idx_zero;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              flag_wr;
    logic              flag_val;
    logic              flag_res;
    logic              up_move;
    logic              dn_move;
    logic              place;
    logic              cand_clr;
    logic              cand_try_l;
    logic              cand_try_r;
    logic              clr_step;
    logic              st_set;
    logic [STAT_W-1:0] st;
    logic              out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       node_ok;
    logic       full;
    logic       empty;
    logic       flag;
    logic       i_zero;
    logic       up_swap;
    logic       l_in;
    logic       r_in;
    logic       cand_set;
    logic       clr_last;
    logic       out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/imhq_ram.sv
`default_nettype none
module imhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/imhq_dp.sv
`default_nettype none
module imhq_dp #(
  parameter int unsigned NODES    = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [imhq_pkg::NODE_W-1:0]      node_id_i,
  input  wire logic [imhq_pkg::KEYIN_W-1:0]     key_value_i,
  input  wire imhq_pkg::dp_cmd_t                cmd_i,
  output imhq_pkg::dp_stat_t                    stat_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [imhq_pkg::NODE_W-1:0]           result_node_o,
  output logic [imhq_pkg::KEYIN_W-1:0]          result_key_o,
  output logic                                  is_queued_o,
  output logic                                  now_empty_o,
  output logic [imhq_pkg::STAT_W-1:0]           status_o
);
  import imhq_pkg::*;

  localparam int unsigned SW = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned XW = SW + 2;
  localparam int unsigned HW = NODE_W + KEY_BITS;

  // Latched transaction
  logic [1:0]          op_q;
  logic [NODE_W-1:0]   node_q;
  logic [KEY_BITS-1:0] key_q;

  // Heap walk state
  logic [CW-1:0]       count_q, count_d;
  logic [SW-1:0]       i_q;
  logic [NODE_W-1:0]   cur_node_q;
  logic [KEY_BITS-1:0] cur_key_q;
  logic [NODE_W-1:0]   cand_node_q;
  logic [KEY_BITS-1:0] cand_key_q;
  logic [SW-1:0]       cand_idx_q;
  logic                cand_set_q;
  logic [SW-1:0]       clr_ptr_q;

  // Result holding
  logic [NODE_W-1:0]   res_node_q;
  logic [KEY_BITS-1:0] res_key_q;
  logic                isq_q;
  logic [STAT_W-1:0]   st_q;
  logic                out_valid_q;
  logic [NODE_W-1:0]   out_node_q;
  logic [KEYIN_W-1:0]  out_key_q;
  logic                out_isq_q;
  logic                out_empty_q;
  logic [STAT_W-1:0]   out_st_q;

  // Memory ports
  logic                h_we, s_we, f_we;
  logic [SW-1:0]       h_waddr, h_raddr, s_waddr, f_waddr;
  logic [HW-1:0]       h_wdata, h_rdata;
  logic [SW-1:0]       s_wdata, s_rdata;
  logic                f_wdata, f_rdata;
  logic [NODE_W-1:0]   h_rd_node;
  logic [KEY_BITS-1:0] h_rd_key;

  // Index arithmetic
  logic [SW-1:0]       par;
  logic [XW-1:0]       l_x, r_x, cnt_x;
  logic [CW-1:0]       cnt_m1;
  logic [KEY_BITS-1:0] best_key;
  logic [SW-1:0]       node_addr;

  assign h_rd_node = h_rdata[HW-1:KEY_BITS];
  assign h_rd_key  = h_rdata[KEY_BITS-1:0];
  assign par       = SW'((i_q - SW'(1)) >> 1);
  assign l_x       = (XW'(i_q) << 1) + XW'(1);
  assign r_x       = (XW'(i_q) << 1) + XW'(2);
  assign cnt_x     = XW'(count_q);
  assign cnt_m1    = count_q - CW'(1);
  assign best_key  = cand_set_q ? cand_key_q : cur_key_q;
  assign node_addr = SW'(node_q);

  // Heap read address
  always_comb begin
    unique case (cmd_i.hsel)
      HA_LAST:   h_raddr = cnt_m1[SW-1:0];
      HA_PARENT: h_raddr = par;
      HA_LEFT:   h_raddr = l_x[SW-1:0];
      HA_RIGHT:  h_raddr = r_x[SW-1:0];
      default:   h_raddr = '0;
    endcase
  end

  // Heap and slot writes: hole gets the parent, the best child or the moving entry
  always_comb begin
    h_we    = cmd_i.place | cmd_i.up_move | cmd_i.dn_move;
    h_waddr = i_q;
    s_we    = h_we;
    s_wdata = i_q;
    if (cmd_i.up_move) begin
      h_wdata = h_rdata;
      s_waddr = SW'(h_rd_node);
    end else if (cmd_i.dn_move) begin
      h_wdata = {cand_node_q, cand_key_q};
      s_waddr = SW'(cand_node_q);
    end else begin
      h_wdata = {cur_node_q, cur_key_q};
      s_waddr = SW'(cur_node_q);
    end
  end

  // Queued flags: clearing pass or membership update
  always_comb begin
    f_we = cmd_i.clr_step | cmd_i.flag_wr;
    if (cmd_i.clr_step) begin
      f_waddr = clr_ptr_q;
      f_wdata = 1'b0;
    end else begin
      f_waddr = cmd_i.flag_res ? SW'(h_rd_node) : node_addr;
      f_wdata = cmd_i.flag_val;
    end
  end

  imhq_ram #(.WIDTH(HW), .DEPTH(NODES)) u_heap (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  imhq_ram #(.WIDTH(SW), .DEPTH(NODES)) u_slot (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (node_addr),
    .rdata_o (s_rdata)
  );

  imhq_ram #(.WIDTH(1), .DEPTH(NODES)) u_flag (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (node_addr),
    .rdata_o (f_rdata)
  );

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cand_set_q  <= 1'b0;
      clr_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.clr_step) begin
        clr_ptr_q <= clr_ptr_q + SW'(1);
      end
      if (cmd_i.cand_clr) begin
        cand_set_q <= 1'b0;
      end else if ((cmd_i.cand_try_l && h_rd_key < cur_key_q) ||
                   (cmd_i.cand_try_r && h_rd_key < best_key)) begin
        cand_set_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= operation_i;
      node_q     <= node_id_i;
      key_q      <= KEY_BITS'(key_value_i);
      res_node_q <= '0;
      res_key_q  <= '0;
      isq_q      <= 1'b0;
      st_q       <= ST_OK;
    end
    if (cmd_i.cur_in) begin
      cur_node_q <= node_q;
      cur_key_q  <= key_q;
    end else if (cmd_i.cur_rd) begin
      cur_node_q <= h_rd_node;
      cur_key_q  <= h_rd_key;
    end
    if (cmd_i.res_rd) begin
      res_node_q <= h_rd_node;
      res_key_q  <= h_rd_key;
    end
    // Walk index
    if (cmd_i.idx_cnt) begin
      i_q <= SW'(count_q);
    end else if (cmd_i.idx_slot) begin
      i_q <= s_rdata;
    end else if (cmd_i.idx_zero) begin
      i_q <= '0;
    end else if (cmd_i.up_move) begin
      i_q <= par;
    end else if (cmd_i.dn_move) begin
      i_q <= cand_idx_q;
    end
    // Best child so far
    if (cmd_i.cand_try_l && h_rd_key < cur_key_q) begin
      cand_node_q <= h_rd_node;
      cand_key_q  <= h_rd_key;
      cand_idx_q  <= l_x[SW-1:0];
    end else if (cmd_i.cand_try_r && h_rd_key < best_key) begin
      cand_node_q <= h_rd_node;
      cand_key_q  <= h_rd_key;
      cand_idx_q  <= r_x[SW-1:0];
    end
    if (cmd_i.st_set) begin
      st_q  <= cmd_i.st;
      isq_q <= (op_q == OP_CONTAINS) && stat_o.node_ok && f_rdata;
    end
    if (cmd_i.out_load) begin
      out_node_q  <= res_node_q;
      out_key_q   <= KEYIN_W'(res_key_q);
      out_isq_q   <= isq_q;
      out_empty_q <= (count_q == '0);
      out_st_q    <= st_q;
    end
  end

  // Status to controller
  always_comb begin
    stat_o.op       = op_q;
    stat_o.node_ok  = (32'(node_q) < NODES);
    stat_o.full     = (32'(count_q) >= NODES);
    stat_o.empty    = (count_q == '0);
    stat_o.flag     = f_rdata;
    stat_o.i_zero   = (i_q == '0);
    stat_o.up_swap  = (cur_key_q < h_rd_key);
    stat_o.l_in     = (l_x < cnt_x);
    stat_o.r_in     = (r_x < cnt_x);
    stat_o.cand_set = cand_set_q;
    stat_o.clr_last = (32'(clr_ptr_q) == NODES - 1);
    stat_o.out_busy = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign result_node_o = out_node_q;
  assign result_key_o  = out_key_q;
  assign is_queued_o   = out_isq_q;
  assign now_empty_o   = out_empty_q;
  assign status_o      = out_st_q;

endmodule
`default_nettype wire

FILE: hdl/imhq_ctrl.sv
`default_nettype none
module imhq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire imhq_pkg::dp_stat_t stat_i,
  output imhq_pkg::dp_cmd_t       cmd_o
);
  import imhq_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_EXL  = 4'd4;
  localparam logic [3:0] S_UP   = 4'd5;
  localparam logic [3:0] S_UPC  = 4'd6;
  localparam logic [3:0] S_DNL  = 4'd7;
  localparam logic [3:0] S_DNR  = 4'd8;
  localparam logic [3:0] S_DNC  = 4'd9;
  localparam logic [3:0] S_DNM  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      // Clear queued flags after reset
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      // Flag, slot and root reads in flight
      S_DEC: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d      = S_FIN;
        cmd_o.st_set = 1'b1;
        cmd_o.st     = ST_OK;
        case (stat_i.op)
          OP_INSERT: begin
            if (!stat_i.node_ok || stat_i.full) begin
              cmd_o.st = ST_FULL;
            end else if (stat_i.flag) begin
              cmd_o.st = ST_DUP;
            end else begin
              cmd_o.cur_in   = 1'b1;
              cmd_o.idx_cnt  = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
              cmd_o.flag_wr  = 1'b1;
              cmd_o.flag_val = 1'b1;
              state_d        = S_UP;
            end
          end
          OP_EXTRACT: begin
            if (stat_i.empty) begin
              cmd_o.st = ST_EMPTY;
            end else begin
              cmd_o.res_rd   = 1'b1;
              cmd_o.flag_wr  = 1'b1;
              cmd_o.flag_res = 1'b1;
              cmd_o.hsel     = HA_LAST;
              cmd_o.cnt_dec  = 1'b1;
              state_d        = S_EXL;
            end
          end
          OP_CHANGE: begin
            if (!stat_i.node_ok || !stat_i.flag) begin
              cmd_o.st = ST_ABSENT;
            end else begin
              cmd_o.cur_in   = 1'b1;
              cmd_o.idx_slot = 1'b1;
              state_d        = S_UP;
            end
          end
          default: begin
          end
        endcase
      end
      // Last entry moves to the root
      S_EXL: begin
        cmd_o.cur_rd   = 1'b1;
        cmd_o.idx_zero = 1'b1;
        state_d        = stat_i.empty ? S_FIN : S_DNL;
      end
      S_UP: begin
        if (stat_i.i_zero) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.hsel = HA_PARENT;
          state_d    = S_UPC;
        end
      end
      S_UPC: begin
        if (stat_i.up_swap) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_DNL: begin
        if (!stat_i.l_in) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.hsel     = HA_LEFT;
          cmd_o.cand_clr = 1'b1;
          state_d        = S_DNR;
        end
      end
      S_DNR: begin
        cmd_o.cand_try_l = 1'b1;
        if (stat_i.r_in) begin
          cmd_o.hsel = HA_RIGHT;
          state_d    = S_DNC;
        end else begin
          state_d = S_DNM;
        end
      end
      S_DNC: begin
        cmd_o.cand_try_r = 1'b1;
        state_d          = S_DNM;
      end
      S_DNM: begin
        if (stat_i.cand_set) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DNL;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      // Hand the result to the output register
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/indexed_min_heap_queue.sv
`default_nettype none
// Contains and rejected operations go from the check straight to the result; insert and
// change climb toward the root with one parent compare per level, stopping below the root
// when the parent key is not larger; extract moves the last entry to the root and, unless
// that empties the queue, descends with a left and, if present, a right child compare per
// level (left and right child reads share one heap read port). One transaction at a time.
// Reset: after rst_ni the queued flags are cleared, input not ready.
module indexed_min_heap_queue #(
  parameter int unsigned NODES    = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   operation_i,
  input  wire logic [imhq_pkg::NODE_W-1:0]  node_id_i,
  input  wire logic [imhq_pkg::KEYIN_W-1:0] key_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [imhq_pkg::NODE_W-1:0]       result_node_o,
  output logic [imhq_pkg::KEYIN_W-1:0]      result_key_o,
  output logic                              is_queued_o,
  output logic                              now_empty_o,
  output logic [imhq_pkg::STAT_W-1:0]       status_o
);
  import imhq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  imhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  imhq_dp #(.NODES(NODES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .node_id_i     (node_id_i),
    .key_value_i   (key_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_node_o (result_node_o),
    .result_key_o  (result_key_o),
    .is_queued_o   (is_queued_o),
    .now_empty_o   (now_empty_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire
